// ----- hdl/bte_pkg.sv -----
// ----------------------------------------------------------------------------
// bte_pkg
// Shared types, constants and character helpers for the byte text escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package bte_pkg;

   localparam int MaxChars   = 6;   // longest escape run (html entity of 100..255)
   localparam int QueueDepth = 2;   // default depth of the front-to-back queue

   typedef enum logic [1:0] {
      MODE_PERCENT = 2'd0,
      MODE_BSLASH  = 2'd1,
      MODE_HTML    = 2'd2,
      MODE_URL     = 2'd3
   } mode_type;

   localparam logic [7:0] ChPercent = 8'h25;
   localparam logic [7:0] ChBslash  = 8'h5C;
   localparam logic [7:0] ChX       = 8'h78;
   localparam logic [7:0] ChAmp     = 8'h26;
   localparam logic [7:0] ChHash    = 8'h23;
   localparam logic [7:0] ChSemi    = 8'h3B;
   localparam logic [7:0] ChPlus    = 8'h2B;
   localparam logic [7:0] ChSpace   = 8'h20;
   localparam logic [7:0] ChZero    = 8'h30;
   localparam logic [7:0] ChNine    = 8'h39;
   localparam logic [7:0] ChUpperA  = 8'h41;
   localparam logic [7:0] ChUpperZ  = 8'h5A;
   localparam logic [7:0] ChLowerA  = 8'h61;
   localparam logic [7:0] ChLowerZ  = 8'h7A;

   // One classified item: the characters of its run, first in slot 0.
   typedef struct packed {
      logic [2:0]                  len;
      logic [MaxChars-1:0][7:0]    chars;
   } desc_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] n8;
      n8 = {4'd0, nib};
      return (nib < 4'd10) ? (ChZero + n8) : (ChLowerA + n8 - 8'd10);
   endfunction

   function automatic logic is_alnum(input logic [7:0] b);
      return (b >= ChZero && b <= ChNine) ||
             (b >= ChUpperA && b <= ChUpperZ) ||
             (b >= ChLowerA && b <= ChLowerZ);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/bte_front.sv -----
// ----------------------------------------------------------------------------
// bte_front
// Classifies one raw byte into its escape run (characters plus length).
// ----------------------------------------------------------------------------
`default_nettype none

module bte_front (
   input  wire logic [7:0]       in_byte,
   input  wire logic [1:0]       mode,
   output bte_pkg::desc_type     desc
);

   logic [1:0]  hund;
   logic [6:0]  rem;     // byte minus hundreds, below 100
   logic [14:0] prod;    // rem * 205, >> 11 gives rem / 10 for rem < 180
   logic [3:0]  tens;
   logic [3:0]  ones;
   logic [7:0]  hund_c;
   logic [7:0]  tens_c;
   logic [7:0]  ones_c;
   logic [7:0]  hex_hi;
   logic [7:0]  hex_lo;

   always_comb begin
      priority if (in_byte >= 8'd200) begin
         hund = 2'd2;
         rem  = 7'(in_byte - 8'd200);
      end else if (in_byte >= 8'd100) begin
         hund = 2'd1;
         rem  = 7'(in_byte - 8'd100);
      end else begin
         hund = 2'd0;
         rem  = in_byte[6:0];
      end
      prod   = 15'(rem) * 15'd205;
      tens   = prod[14:11];
      ones   = 4'(rem - 7'(tens) * 7'd10);
      hund_c = bte_pkg::ChZero + {6'd0, hund};
      tens_c = bte_pkg::ChZero + {4'd0, tens};
      ones_c = bte_pkg::ChZero + {4'd0, ones};
      hex_hi = bte_pkg::hex_char(in_byte[7:4]);
      hex_lo = bte_pkg::hex_char(in_byte[3:0]);
   end

   always_comb begin
      desc = '0;
      unique case (bte_pkg::mode_type'(mode))
         bte_pkg::MODE_PERCENT: begin
            desc.len      = 3'd3;
            desc.chars[0] = bte_pkg::ChPercent;
            desc.chars[1] = hex_hi;
            desc.chars[2] = hex_lo;
         end
         bte_pkg::MODE_BSLASH: begin
            desc.len      = 3'd4;
            desc.chars[0] = bte_pkg::ChBslash;
            desc.chars[1] = bte_pkg::ChX;
            desc.chars[2] = hex_hi;
            desc.chars[3] = hex_lo;
         end
         bte_pkg::MODE_HTML: begin
            desc.chars[0] = bte_pkg::ChAmp;
            desc.chars[1] = bte_pkg::ChHash;
            priority if (hund != 2'd0) begin
               desc.len      = 3'd6;
               desc.chars[2] = hund_c;
               desc.chars[3] = tens_c;
               desc.chars[4] = ones_c;
               desc.chars[5] = bte_pkg::ChSemi;
            end else if (tens != 4'd0) begin
               desc.len      = 3'd5;
               desc.chars[2] = tens_c;
               desc.chars[3] = ones_c;
               desc.chars[4] = bte_pkg::ChSemi;
            end else begin
               desc.len      = 3'd4;
               desc.chars[2] = ones_c;
               desc.chars[3] = bte_pkg::ChSemi;
            end
         end
         bte_pkg::MODE_URL: begin
            priority if (bte_pkg::is_alnum(in_byte)) begin
               desc.len      = 3'd1;
               desc.chars[0] = in_byte;
            end else if (in_byte == bte_pkg::ChSpace) begin
               desc.len      = 3'd1;
               desc.chars[0] = bte_pkg::ChPlus;
            end else begin
               desc.len      = 3'd3;
               desc.chars[0] = bte_pkg::ChPercent;
               desc.chars[1] = hex_hi;
               desc.chars[2] = hex_lo;
            end
         end
         default: desc = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/bte_queue.sv -----
// ----------------------------------------------------------------------------
// bte_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bte_queue #(
   parameter int DEPTH = bte_pkg::QueueDepth   // 2 or more
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  bte_pkg::desc_type     push_desc,
   output logic                  not_full,
   input  wire logic             pop,
   output logic                  not_empty,
   output bte_pkg::desc_type     head_desc
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
   localparam logic [CW-1:0] Full    = CW'(DEPTH);

   bte_pkg::desc_type  mem_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff;
   logic [AW-1:0]      rd_ptr_ff;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      cnt_in;

   assign not_full  = (cnt_ff != Full);
   assign not_empty = (cnt_ff != '0);
   assign head_desc = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + AW'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/bte_back.sv -----
// ----------------------------------------------------------------------------
// bte_back
// Serializes the head item's run into an output register, one character per
// cycle while out_ready allows; pops the queue on the last character.
// ----------------------------------------------------------------------------
`default_nettype none

module bte_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  bte_pkg::desc_type     head_desc,
   output logic                  pop,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [7:0]            out_char,
   output logic                  out_last
);

   logic       valid_ff;
   logic [7:0] char_ff;
   logic       last_ff;
   logic [2:0] idx_ff;
   logic       advance;
   logic       is_last;

   assign advance   = !valid_ff || out_ready;
   assign is_last   = (idx_ff == head_desc.len - 3'd1);
   assign pop       = advance && head_valid && is_last;
   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

   always_ff @(posedge clock) begin
      if (advance && head_valid) begin
         char_ff <= head_desc.chars[idx_ff];
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (advance) begin
         valid_ff <= head_valid;
         if (head_valid) begin
            idx_ff <= is_last ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/byte_text_escaper_top.sv -----
// ----------------------------------------------------------------------------
// byte_text_escaper_top
// Escapes one raw byte per item into a run of ASCII characters.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  req_      in   req_tvalid/req_tready  tdata[7:0] = in_byte
//  rsp_      out  rsp_tvalid/rsp_tready  tdata[7:0] = out_char, tlast = last_char
//  csr_      in   csr_wr_en              wr_data[1:0] = escape_mode
//
//  Output runs at one character per cycle while rsp_tready allows, from the
//  single-character back-end serializer; a byte's run is 1 to 6 characters.
//  Input accepts one byte per cycle while the queue has room (QUEUE_DEPTH).
//  An accepted byte passes the queue, then the output register, to rsp_.
//  reset is synchronous, active high; it empties the queue and output
//  register and sets escape_mode to percent-hex.
//  rsp_tready low holds the output register; the queue then fills and
//  req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_text_escaper_top #(
   parameter int QUEUE_DEPTH = bte_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] in_byte
   // character output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [7:0] out_char
   output logic             rsp_tlast,    // last_char
   // mode register
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_wr_data   // [1:0] escape_mode
);

   logic [1:0]         mode_ff;
   bte_pkg::desc_type  front_desc;
   bte_pkg::desc_type  head_desc;
   logic               push;
   logic               q_not_full;
   logic               q_valid;
   logic               q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bte_pkg::MODE_PERCENT;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   assign req_tready = q_not_full;
   assign push       = req_tvalid && q_not_full;

   // Front: classify the byte under the current mode
   bte_front u_front (
      .in_byte (req_tdata),
      .mode    (mode_ff),
      .desc    (front_desc)
   );

   // Queue decouples acceptance from character output
   bte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (front_desc),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_desc (head_desc)
   );

   // Back: one character per cycle into the output register; rsp_tready stalls it
   bte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_desc  (head_desc),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_char   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

   // Queued run lengths are always 1..6
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> (head_desc.len >= 3'd1 && head_desc.len <= 3'd6))
      else $error("queued run length out of range");

   // Pop only from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // A pop always puts the run's last character in the output register
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_tvalid && rsp_tlast))
      else $error("pop without last character");

   // An accepted byte is in the queue next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      push |=> q_valid)
      else $error("accepted item not queued");

endmodule

`default_nettype wire
